// ===== src/dtcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the colour ramp for the reprojection block.
// No dependencies.
package dtcr_pkg;

  localparam int IMAGE_COLS = 640;
  localparam int IMAGE_ROWS = 480;
  localparam int ZB_SIZE    = IMAGE_COLS * IMAGE_ROWS;
  localparam int ZB_AW      = $clog2(ZB_SIZE);

  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int DISP_W = 14;
  localparam int SHF_W  = 11;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;

  localparam int QW = 56;      // projection sums
  localparam int DW = QW + 2;  // divider operands

  localparam logic [IDX_W-1:0] REG_SHIFT_OFFSET = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_A       = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW0_B       = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_A       = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW1_B       = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_A       = 3'd5;
  localparam logic [IDX_W-1:0] REG_ROW2_B       = 3'd6;

  localparam logic [15:0] SHIFT_OFFSET_RST = 16'd17344;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // pv = floor(s^3*9216/2^33) = (cube*9) >> 23
  function automatic rgb_t ramp_color(input logic [32:0] cube);
    logic [36:0] prod;
    logic [13:0] pv;
    logic [7:0]  lb;
    rgb_t        c;
    prod = {4'd0, cube} + {1'b0, cube, 3'd0};
    pv   = prod[36:23];
    lb   = pv[7:0];
    case (pv[13:8])
      6'd0:    c = '{8'hff, 8'hff - lb, 8'hff - lb};
      6'd1:    c = '{8'hff, lb, 8'h00};
      6'd2:    c = '{8'hff - lb, 8'hff, 8'h00};
      6'd3:    c = '{8'h00, 8'hff, lb};
      6'd4:    c = '{8'h00, 8'hff - lb, 8'hff};
      6'd5:    c = '{8'h00, 8'h00, 8'hff - lb};
      default: c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage

// ===== src/depth_to_color_reprojection_top.sv =====
`timescale 1ns / 1ps
// Depth-to-colour reprojection: sequencer, shared multiplier, divider, z-buffer.
// Depends on dtcr_pkg.
//
// Use:
//  - in_*: one request per depth pixel in raster order. in_tuser = kind
//    (0 pixel, 1 frame start), in_tdata[10:0] = depth shift.
//  - out_*: one result per request, held in an output register until taken.
//  - cfg_*: plain register writes, only while the block is idle.
// Steps per pixel request: accept, the shared 32x18 multiplier (nine matrix
//  terms, then the shift cube), two 58-bit restoring divisions at one quotient
//  bit a cycle (skipped on a zero divisor), z-buffer read-compare-write, then
//  the result load.
// Frame start: the z-buffer is swept to zero one entry a cycle, then an
//  all-zero result follows.
// Reset: counters cleared and the same sweep runs; in_tready
//  stays low until it ends.
// Stall: a result waits in the output register; the next request may be
//  accepted and processed meanwhile, but its result is held back until the
//  register frees.
module depth_to_color_reprojection_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [10:0] depth_shift
  input  logic                        in_tuser,   // [0] kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [9:0] target_col, [18:10] target_row, [19] target_valid,
  // [33:20] disparity_out, [34] zbuffer_won, [35] fetch_color,
  // [43:36] color_red, [51:44] color_green, [59:52] color_blue
  output logic [63:0]                 out_tdata,
  input  logic                        cfg_we,
  input  logic [dtcr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dtcr_pkg::CFG_W-1:0]  cfg_wdata
);
  import dtcr_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_ZRD   = 7'b0010000,
    ST_ZWR   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] shift_offset_r;
  logic [CFG_W-1:0] coef_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_offset_r <= SHIFT_OFFSET_RST;
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT_OFFSET: shift_offset_r <= cfg_wdata[15:0];
        REG_ROW0_A:       coef_r[0] <= cfg_wdata;
        REG_ROW0_B:       coef_r[1] <= cfg_wdata;
        REG_ROW1_A:       coef_r[2] <= cfg_wdata;
        REG_ROW1_B:       coef_r[3] <= cfg_wdata;
        REG_ROW2_A:       coef_r[4] <= cfg_wdata;
        REG_ROW2_B:       coef_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item registers
  logic              fs_r;
  logic [SHF_W-1:0]  shift_r;
  logic [16:0]       dq_r;
  logic [DISP_W-1:0] disp_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [3:0]        mstep_r;
  logic signed [QW-1:0] q0_r, q1_r, q2_r;
  logic [21:0]       sq_r;
  logic [32:0]       cube_r;

  logic [ZB_AW-1:0]  clr_addr_r;

  // divider
  logic              dsel_r;     // 0: column, 1: row
  logic [5:0]        dcnt_r;
  logic [DW-1:0]     dnum_r;     // dividend, becomes quotient
  logic [DW-1:0]     dden_r;
  logic [DW:0]       drem_r;
  logic              dneg_r;
  logic [COL_W-1:0]  u_r;
  logic [ROW_W-1:0]  v_r;
  logic              tvalid_r;

  // z-buffer
  logic [DISP_W-1:0] zb [ZB_SIZE];
  logic [DISP_W-1:0] zb_q_r;
  logic [ZB_AW-1:0]  zaddr_r;
  logic              won_r;
  logic              zb_we;
  logic [ZB_AW-1:0]  zb_waddr;
  logic [DISP_W-1:0] zb_wdata;
  logic [ZB_AW-1:0]  zb_raddr;

  // output register
  logic        out_valid_r;
  logic [63:0] out_data_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  wire in_acc   = in_tvalid && in_tready;
  wire out_free = !out_valid_r || out_tready;

  // input front end
  logic signed [17:0] diff;
  logic [16:0]        dq_in;
  logic [17:0]        disp_sum;
  always_comb begin
    diff     = $signed({2'b00, shift_offset_r}) - $signed({3'b000, in_tdata[10:0], 4'd0});
    dq_in    = (diff > 0) ? diff[16:0] : 17'd0;
    disp_sum = {1'b0, dq_in} + 18'd3;
  end

  // shared multiplier
  logic signed [31:0] ma;
  logic signed [17:0] mb;
  logic signed [49:0] prod;
  logic signed [QW-1:0] prod_sh, ck_sh;
  logic [2:0] crow;
  always_comb begin
    ma   = '0;
    mb   = '0;
    crow = 3'd0;
    case (mstep_r) inside
      4'd0, 4'd3, 4'd6: begin
        crow = (mstep_r == 4'd0) ? 3'd0 : (mstep_r == 4'd3) ? 3'd2 : 3'd4;
        ma   = coef_r[crow][31:0];
        mb   = $signed({8'd0, col_r});
      end
      4'd1, 4'd4, 4'd7: begin
        crow = (mstep_r == 4'd1) ? 3'd0 : (mstep_r == 4'd4) ? 3'd2 : 3'd4;
        ma   = coef_r[crow][63:32];
        mb   = $signed({9'd0, row_r});
      end
      4'd2, 4'd5, 4'd8: begin
        crow = (mstep_r == 4'd2) ? 3'd1 : (mstep_r == 4'd5) ? 3'd3 : 3'd5;
        ma   = coef_r[crow][31:0];
        mb   = $signed({1'b0, dq_r});
      end
      4'd9: begin
        ma = $signed({21'd0, shift_r});
        mb = $signed({7'd0, shift_r});
      end
      4'd10: begin
        ma = $signed({10'd0, sq_r});
        mb = $signed({7'd0, shift_r});
      end
      default: ;
    endcase
    prod    = 50'(ma) * 50'(mb);
    prod_sh = QW'(prod) <<< 7;
    // constant term of the row whose first step this is
    ck_sh   = QW'($signed(coef_r[crow + 3'd1][63:32])) <<< 7;
  end

  // divider operand set-up for either division
  logic signed [DW-1:0] nsig, dsig;
  logic [DW-1:0]        nmag, dmag;
  always_comb begin
    nsig = (DW'(dsel_r ? q0_r : q1_r) <<< 1) + DW'(q2_r);
    dsig = DW'(q2_r) <<< 1;
    nmag = nsig[DW-1] ? DW'(-nsig) : nsig;
    dmag = dsig[DW-1] ? DW'(-dsig) : dsig;
  end
  // nsig uses q1 while dsel_r is clear, as it still is at load time of the second
  // division; the first load uses nsig0 below, whatever dsel_r holds.
  logic signed [DW-1:0] nsig0;
  logic [DW-1:0]        nmag0;
  always_comb begin
    nsig0 = (DW'(q0_r) <<< 1) + DW'(q2_r);
    nmag0 = nsig0[DW-1] ? DW'(-nsig0) : nsig0;
  end

  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW-1:0] quot_fin;
  logic          qneg, col_ok, row_ok;
  always_comb begin
    rem_sh   = {drem_r[DW-1:0], dnum_r[DW-1]};
    rem_ge   = rem_sh >= {1'b0, dden_r};
    quot_fin = {dnum_r[DW-2:0], rem_ge};
    qneg     = dneg_r && (quot_fin != '0);
    col_ok   = !qneg && (quot_fin < DW'(IMAGE_COLS));
    row_ok   = !qneg && (quot_fin < DW'(IMAGE_ROWS));
  end

  wire [ZB_AW-1:0] zaddr_nxt = ZB_AW'(v_r) * ZB_AW'(IMAGE_COLS) + ZB_AW'(u_r);

  always_comb begin
    zb_raddr = zaddr_nxt;
    zb_we    = 1'b0;
    zb_waddr = zaddr_r;
    zb_wdata = disp_r;
    if (state_r == ST_CLEAR) begin
      zb_we    = 1'b1;
      zb_waddr = clr_addr_r;
      zb_wdata = '0;
    end else if (state_r == ST_ZWR && zb_q_r < disp_r) begin
      zb_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (zb_we) zb[zb_waddr] <= zb_wdata;
    zb_q_r <= zb[zb_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == ZB_AW'(ZB_SIZE - 1)) state_nxt = fs_r ? ST_DONE : ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = in_tuser ? ST_CLEAR : ST_MUL;
      ST_MUL:   if (mstep_r == 4'd10) state_nxt = (q2_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (dcnt_r == 6'(DW - 1)) begin
          if (!dsel_r) state_nxt = col_ok ? ST_DIV : ST_DONE;
          else         state_nxt = row_ok ? ST_ZRD : ST_DONE;
        end
      end
      ST_ZRD:   state_nxt = ST_ZWR;
      ST_ZWR:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  rgb_t rgb;
  always_comb rgb = ramp_color(cube_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      fs_r        <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      mstep_r     <= '0;
      dcnt_r      <= '0;
      dsel_r      <= 1'b0;
      tvalid_r    <= 1'b0;
      won_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result taken; a new one loads in ST_DONE instead
      if (out_valid_r && out_tready && state_r != ST_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_CLEAR: clr_addr_r <= clr_addr_r + 1'b1;
        ST_IDLE: if (in_acc) begin
          fs_r       <= in_tuser;
          shift_r    <= in_tdata[10:0];
          dq_r       <= dq_in;
          disp_r     <= disp_sum[16:3];
          mstep_r    <= '0;
          tvalid_r   <= 1'b0;
          won_r      <= 1'b0;
          u_r        <= '0;
          v_r        <= '0;
          clr_addr_r <= '0;
          if (in_tuser) begin
            col_r <= '0;
            row_r <= '0;
          end
        end
        ST_MUL: begin
          mstep_r <= mstep_r + 1'b1;
          case (mstep_r)
            4'd0:  q0_r <= prod_sh + ck_sh;
            4'd1:  q0_r <= q0_r + prod_sh;
            4'd2:  q0_r <= q0_r + QW'(prod);
            4'd3:  q1_r <= prod_sh + ck_sh;
            4'd4:  q1_r <= q1_r + prod_sh;
            4'd5:  q1_r <= q1_r + QW'(prod);
            4'd6:  q2_r <= prod_sh + ck_sh;
            4'd7:  q2_r <= q2_r + prod_sh;
            4'd8:  q2_r <= q2_r + QW'(prod);
            4'd9:  sq_r <= prod[21:0];
            default: cube_r <= prod[32:0];
          endcase
          if (mstep_r == 4'd10) begin
            dsel_r <= 1'b0;
            dcnt_r <= '0;
            drem_r <= '0;
            dnum_r <= nmag0;
            dden_r <= dmag;
            dneg_r <= nsig0[DW-1] ^ dsig[DW-1];
          end
        end
        ST_DIV: begin
          if (dcnt_r == 6'(DW - 1)) begin
            if (!dsel_r) begin
              u_r    <= quot_fin[COL_W-1:0];
              dsel_r <= 1'b1;
              dcnt_r <= '0;
              drem_r <= '0;
              // row numerator: dsel_r still clear here, so select q1 directly
              dnum_r <= nmag;
              dden_r <= dmag;
              dneg_r <= nsig[DW-1] ^ dsig[DW-1];
            end else begin
              v_r      <= quot_fin[ROW_W-1:0];
              tvalid_r <= row_ok;
            end
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            dnum_r <= quot_fin;
            drem_r <= rem_ge ? (rem_sh - {1'b0, dden_r}) : rem_sh;
          end
        end
        ST_ZRD: zaddr_r <= zaddr_nxt;
        ST_ZWR: won_r <= (zb_q_r < disp_r);
        ST_DONE: if (out_free) begin
          out_valid_r <= 1'b1;
          if (fs_r) begin
            out_data_r <= '0;
          end else begin
            out_data_r <= {4'd0, rgb.blue, rgb.green, rgb.red,
                           tvalid_r && (dq_r != '0), won_r, disp_r,
                           tvalid_r, tvalid_r ? v_r : ROW_W'(0),
                           tvalid_r ? u_r : COL_W'(0)};
            if (col_r == COL_W'(IMAGE_COLS - 1)) begin
              col_r <= '0;
              row_r <= (row_r == ROW_W'(IMAGE_ROWS - 1)) ? '0 : row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/tb_depth_to_color_reprojection_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_to_color_reprojection_top: predicts every result
// from its own copy of the registers, raster counters and z-buffer. Depends on dtcr_pkg.
module tb_depth_to_color_reprojection_top;
  import dtcr_pkg::*;

  // unused register slot, writes must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic             KIND_PIXEL = 1'b0;
  localparam logic             KIND_FRAME = 1'b1;
  // the block may still be busy after a result; allow a full pixel's latency
  localparam int               DRAIN_CYCLES = 300;

  typedef enum int {MAP_ZERO_DIV, MAP_IDENTITY, MAP_MIRROR, MAP_SCALED, MAP_RANDOM} map_t;

  typedef struct packed {
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              fetch;
    logic              won;
    logic [DISP_W-1:0] disp;
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } pixel_res_t;

  // Prediction of the reprojection plus the queue of expected results
  class reprojection_checker_t;
    logic [15:0]       offset;
    logic [CFG_W-1:0]  coef [1:6];
    logic [DISP_W-1:0] zbuf [ZB_SIZE];
    int                col_cnt, row_cnt;
    pixel_res_t        expected_px [$];
    int                errors;

    function new();
      offset = SHIFT_OFFSET_RST;
      foreach (coef[i]) coef[i] = '0;
      foreach (zbuf[i]) zbuf[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_SHIFT_OFFSET) offset = val[15:0];
      else if (idx >= REG_ROW0_A && idx <= REG_ROW2_B) coef[idx] = val;
    endfunction

    function longint qword(logic [CFG_W-1:0] r, bit hi);
      logic signed [31:0] w;
      w = hi ? r[63:32] : r[31:0];
      return longint'(w);
    endfunction

    // one matrix row, everything scaled by 2^23
    function longint row_sum(int r, longint dq);
      logic [CFG_W-1:0] a, b;
      a = coef[REG_ROW0_A + 2*r];
      b = coef[REG_ROW0_B + 2*r];
      return (qword(a, 0) * col_cnt + qword(a, 1) * row_cnt) * 128
             + qword(b, 0) * dq + qword(b, 1) * 128;
    endfunction

    function void project_pixel(logic kind, logic [SHF_W-1:0] shift);
      pixel_res_t e;
      longint diff, dq, q0, q1, q2, u, v, s, pv, lb;
      int idx;
      e = '0;
      if (kind == KIND_FRAME) begin
        foreach (zbuf[i]) zbuf[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        expected_px.insert(expected_px.size(), e);
        return;
      end
      diff = longint'(offset) - longint'(shift) * 16;
      dq = diff > 0 ? diff : 0;
      e.disp = DISP_W'((dq + 3) >>> 3);
      q0 = row_sum(0, dq);
      q1 = row_sum(1, dq);
      q2 = row_sum(2, dq);
      if (q2 != 0) begin
        u = (2 * q0 + q2) / (2 * q2);
        v = (2 * q1 + q2) / (2 * q2);
        if (u >= 0 && v >= 0 && u < IMAGE_COLS && v < IMAGE_ROWS) begin
          e.valid = 1'b1;
          e.col = COL_W'(u);
          e.row = ROW_W'(v);
          idx = int'(v) * IMAGE_COLS + int'(u);
          if (zbuf[idx] < e.disp) begin
            zbuf[idx] = e.disp;
            e.won = 1'b1;
          end
          e.fetch = dq > 0;
        end
      end
      // gamma ramp of the raw shift
      s = shift;
      pv = (s * s * s * 9216) >>> 33;
      lb = pv & 255;
      case (pv >>> 8)
        0: {e.red, e.green, e.blue} = {8'd255, 8'(255 - lb), 8'(255 - lb)};
        1: {e.red, e.green, e.blue} = {8'd255, 8'(lb), 8'd0};
        2: {e.red, e.green, e.blue} = {8'(255 - lb), 8'd255, 8'd0};
        3: {e.red, e.green, e.blue} = {8'd0, 8'd255, 8'(lb)};
        4: {e.red, e.green, e.blue} = {8'd0, 8'(255 - lb), 8'd255};
        5: {e.red, e.green, e.blue} = {8'd0, 8'd0, 8'(255 - lb)};
        default: {e.red, e.green, e.blue} = 24'd0;
      endcase
      expected_px.insert(expected_px.size(), e);
      col_cnt++;
      if (col_cnt >= IMAGE_COLS) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= IMAGE_ROWS) row_cnt = 0;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task cmp_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(logic [63:0] data);
      pixel_res_t g, e;
      g = data[59:0];
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      e = expected_px.pop_front();
      cmp_field("target_col", g.col, e.col);
      cmp_field("target_row", g.row, e.row);
      cmp_field("target_valid", g.valid, e.valid);
      cmp_field("disparity_out", g.disp, e.disp);
      cmp_field("zbuffer_won", g.won, e.won);
      cmp_field("fetch_color", g.fetch, e.fetch);
      cmp_field("color_red", g.red, e.red);
      cmp_field("color_green", g.green, e.green);
      cmp_field("color_blue", g.blue, e.blue);
      if (data[63:60] != 4'd0) report("padding bits set");
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [63:0]       out_tdata;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  reprojection_checker_t chk;
  bit                    calm;   // no idling or stalls on either side

  depth_to_color_reprojection_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: bounds the run, covering the reset sweep, one frame clear and all pixels.
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: check on each taken result, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_result(out_tdata);
    out_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // One request; random idle cycles ahead of it, held until taken
  task send_px(logic kind, logic [SHF_W-1:0] shift);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, shift};
    do @(posedge clk); while (!in_tready);
    chk.project_pixel(kind, shift);
  endtask

  // Sender goes quiet until every expected result is back, then drains
  task wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (chk.expected_px.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes; caller lowers cfg_we once afterwards
  task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    chk.set_reg(idx, val);
  endtask

  function logic [31:0] srand(int mag);
    return 32'($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  task program_map(map_t mode, logic [15:0] off, bit poke_unused);
    logic [CFG_W-1:0] v [1:6];
    case (mode)
      MAP_IDENTITY: begin
        v[1] = {32'd0, 32'h0001_0000};
        v[2] = {srand(65536 * 8), srand(512)};
        v[3] = {32'h0001_0000, 32'd0};
        v[4] = {srand(65536 * 8), srand(512)};
        v[5] = '0;
        v[6] = {32'h0001_0000, 32'd0};
      end
      MAP_MIRROR: begin
        // negated numerators and divisor, so rounding runs on negative operands
        v[1] = {32'd0, 32'hffff_0000};
        v[2] = {srand(65536 * 4), srand(256)};
        v[3] = {32'hffff_0000, 32'd0};
        v[4] = {srand(65536 * 4), srand(256)};
        v[5] = '0;
        v[6] = {32'hffff_0000, 32'd0};
      end
      MAP_SCALED: begin
        // fractional scaling gives many pixels per target (z-buffer contention)
        v[1] = {srand(8192), 32'($urandom_range(0, 65536))};
        v[2] = {srand(65536 * 64), srand(1024)};
        v[3] = {32'($urandom_range(0, 65536)), srand(8192)};
        v[4] = {srand(65536 * 64), srand(1024)};
        v[5] = {srand(64), srand(64)};
        v[6] = {32'(65536 + $urandom_range(0, 32768)), srand(64)};
      end
      MAP_ZERO_DIV: begin
        for (int i = 1; i <= 4; i++) v[i] = {$urandom, $urandom};
        v[5] = '0;
        v[6] = '0;
      end
      default: for (int i = 1; i <= 6; i++) v[i] = {$urandom, $urandom};
    endcase
    write_reg(REG_SHIFT_OFFSET, {48'($urandom), off});
    write_reg(REG_ROW0_A, v[1]);
    write_reg(REG_ROW0_B, v[2]);
    write_reg(REG_ROW1_A, v[3]);
    write_reg(REG_ROW1_B, v[4]);
    write_reg(REG_ROW2_A, v[5]);
    write_reg(REG_ROW2_B, v[6]);
    if (poke_unused) write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  initial begin
    map_t        plan [10];
    logic [15:0] off;
    int          near;
    logic [SHF_W-1:0] sh;
    logic [SHF_W-1:0] ramp_pts [11];

    chk        = new();
    calm       = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_PIXEL;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    plan = '{MAP_IDENTITY, MAP_SCALED, MAP_MIRROR, MAP_RANDOM, MAP_ZERO_DIV,
             MAP_IDENTITY, MAP_SCALED, MAP_IDENTITY, MAP_SCALED, MAP_MIRROR};
    ramp_pts = '{11'd0, 11'd2047, 11'd1, 11'd700, 11'd900, 11'd1000, 11'd1080,
                 11'd1084, 11'd1150, 11'd1300, 11'd1600};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // reset runs the z-buffer sweep; tready comes up when done
    do @(posedge clk); while (!in_tready);

    // Reset registers: all coefficients zero, so every divisor is zero.
    // Shifts at, just below and just above the zero-disparity point.
    send_px(KIND_PIXEL, 11'd0);
    send_px(KIND_PIXEL, 11'd2047);
    send_px(KIND_PIXEL, 11'd1084);
    send_px(KIND_PIXEL, 11'd1083);
    send_px(KIND_PIXEL, 11'd1085);
    wait_drained();

    // Straight column/row mapping: each pixel lands on itself.
    write_reg(REG_SHIFT_OFFSET, {48'd0, SHIFT_OFFSET_RST});
    write_reg(REG_ROW0_A, {32'd0, 32'h0001_0000});
    write_reg(REG_ROW0_B, '0);
    write_reg(REG_ROW1_A, {32'h0001_0000, 32'd0});
    write_reg(REG_ROW1_B, '0);
    write_reg(REG_ROW2_A, '0);
    write_reg(REG_ROW2_B, {32'h0001_0000, 32'd0});
    cfg_we <= 1'b0;
    // shifts in ramp segments 0, 1, 3, 4 and 5 and in the black range, plus both extremes
    foreach (ramp_pts[i]) send_px(KIND_PIXEL, ramp_pts[i]);
    // frame start: store and counters cleared, so mapping restarts at column 0
    send_px(KIND_FRAME, 11'd2047);
    send_px(KIND_PIXEL, 11'd0);
    send_px(KIND_PIXEL, 11'd500);
    send_px(KIND_PIXEL, 11'd1084);
    wait_drained();

    // Random phases, each with a fresh mapping
    for (int p = 0; p < 10; p++) begin
      off = (p == 0) ? 16'd0 : (p == 5) ? 16'hffff : 16'($urandom_range(8000, 40000));
      program_map(plan[p], off, p == 3);
      calm = (p == 2);
      for (int n = 0; n < 153; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          sh = 11'($urandom_range(0, 2047));
        end else begin
          // close to the zero-disparity shift, where disparity is small
          near = int'(off >> 4) - int'($urandom_range(0, 300)) + 8;
          sh = near < 0 ? 11'd0 : near > 2047 ? 11'd2047 : 11'(near);
        end
        send_px(KIND_PIXEL, sh);
      end
      wait_drained();
      calm = 1'b0;
    end

    if (chk.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== depth_to_color_reprojection_top.f =====
src/dtcr_pkg.sv
src/depth_to_color_reprojection_top.sv
bench/tb_depth_to_color_reprojection_top.sv
